// ===== hdl/ctpt_pkg.sv =====
`default_nettype none

package ctpt_pkg;

    // Command codes
    localparam logic [3:0] CMD_NONE         = 4'd0;
    localparam logic [3:0] CMD_SAVE_CFG     = 4'd1;
    localparam logic [3:0] CMD_UPDATE_CFG   = 4'd2;
    localparam logic [3:0] CMD_RECEIVE_PASS = 4'd3;
    localparam logic [3:0] CMD_CLEAR        = 4'd4;
    localparam logic [3:0] CMD_PUT_POINT    = 4'd5;
    localparam logic [3:0] CMD_REWIND       = 4'd6;
    localparam logic [3:0] CMD_GET_POINT    = 4'd7;
    localparam logic [3:0] CMD_MARK_END     = 4'd8;
    localparam logic [3:0] CMD_FACTORY      = 4'd9;
    localparam logic [3:0] CMD_DATA_CONNECT = 4'd10;

    typedef logic [2:0] status_t;
    typedef logic [2:0] event_t;

    // Status codes
    localparam status_t ST_NULL     = 3'd0;
    localparam status_t ST_CLEARED  = 3'd1;
    localparam status_t ST_RECEIVED = 3'd2;
    localparam status_t ST_REWOUND  = 3'd3;
    localparam status_t ST_SENT     = 3'd4;
    localparam status_t ST_END      = 3'd5;

    // Event codes
    localparam event_t EV_NONE         = 3'd0;
    localparam event_t EV_SAVE_CFG     = 3'd1;
    localparam event_t EV_UPDATE_CFG   = 3'd2;
    localparam event_t EV_RECEIVE_PASS = 3'd3;
    localparam event_t EV_FACTORY      = 3'd4;
    localparam event_t EV_DATA_CONNECT = 3'd5;

    typedef struct packed {
        logic    status_written;
        status_t status_code;
        event_t  event_code;
        logic    point_sent;
    } resp_t;

endpackage

`default_nettype wire

// ===== hdl/ctpt_table_ram.sv =====
`default_nettype none

module ctpt_table_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] point_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Single port: write or read, read data registered, valid in the next cycle and held
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                point_mem[addr] <= wdata;
            end else begin
                rdata_reg <= point_mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/ctpt_cmd_ctrl.sv =====
`default_nettype none

module ctpt_cmd_ctrl #(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned POS_W       = 7,
    parameter int unsigned ADDR_W      = 6
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cmd_fire,
    input  wire logic [3:0]              command,
    input  wire logic [15:0]             value_a,
    input  wire logic [15:0]             value_b,
    output logic                         mem_en,
    output logic                         mem_we,
    output logic      [ADDR_W-1:0]       mem_addr,
    output logic      [31:0]             mem_wdata,
    output ctpt_pkg::resp_t              resp,
    output logic      [POS_W-1:0]        end_value
);
    import ctpt_pkg::*;

    localparam logic [POS_W-1:0] DEPTH_VAL = POS_W'(TABLE_DEPTH);

    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic             access;
    logic             write_access;

    always_comb begin
        resp                = '0;
        resp.status_written = 1'b1;
        position_next       = position_reg;
        end_next            = end_reg;
        access              = 1'b0;
        write_access        = 1'b0;
        case (command)
            CMD_SAVE_CFG:     resp.event_code = EV_SAVE_CFG;
            CMD_UPDATE_CFG:   resp.event_code = EV_UPDATE_CFG;
            CMD_RECEIVE_PASS: resp.event_code = EV_RECEIVE_PASS;
            CMD_FACTORY:      resp.event_code = EV_FACTORY;
            CMD_DATA_CONNECT: resp.event_code = EV_DATA_CONNECT;
            CMD_CLEAR: begin
                position_next    = '0;
                end_next         = '0;
                resp.status_code = ST_CLEARED;
            end
            CMD_PUT_POINT: begin
                if (position_reg >= DEPTH_VAL) begin
                    end_next         = DEPTH_VAL;
                    resp.status_code = ST_END;
                end else begin
                    access           = 1'b1;
                    write_access     = 1'b1;
                    position_next    = position_reg + POS_W'(1);
                    resp.status_code = ST_RECEIVED;
                end
            end
            CMD_REWIND: begin
                position_next    = '0;
                resp.status_code = ST_REWOUND;
            end
            CMD_GET_POINT: begin
                if (position_reg >= end_reg || position_reg >= DEPTH_VAL) begin
                    resp.status_code = ST_END;
                end else begin
                    access           = 1'b1;
                    position_next    = position_reg + POS_W'(1);
                    resp.point_sent  = 1'b1;
                    resp.status_code = ST_SENT;
                end
            end
            CMD_MARK_END: begin
                end_next         = position_reg;
                resp.status_code = ST_END;
            end
            default: resp.status_written = 1'b0;
        endcase
    end

    // Drive the table only for an accepted transaction
    assign mem_en    = cmd_fire && access;
    assign mem_we    = write_access;
    assign mem_addr  = position_reg[ADDR_W-1:0];
    assign mem_wdata = {value_a, value_b};
    assign end_value = end_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            end_reg      <= '0;
        end else if (cmd_fire) begin
            position_reg <= position_next;
            end_reg      <= end_next;
        end
    end

    a_position_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= DEPTH_VAL && end_reg <= DEPTH_VAL)
        else $error("position or end count beyond table depth");

    a_access_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_en |-> position_reg < DEPTH_VAL)
        else $error("table access outside the table");

    a_clear_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_fire && command == CMD_CLEAR |=> position_reg == '0 && end_reg == '0)
        else $error("clear did not reset position and end count");

endmodule

`default_nettype wire

// ===== hdl/calibration_table_command_port.sv =====
`default_nettype none

// Calibration table command port. Each input transaction carries one command
// and two 16-bit transfer words; each yields exactly one result transaction
// in order. The block keeps a table of TABLE_DEPTH (distance, volume) pairs in
// a single-port synchronous memory, with a shared write/read position and an
// end count in flip-flops. Commands: clear (position and end count to zero,
// table contents kept), put point (store at the position and advance, or
// report table end and set the end count to full), rewind, get point (return
// the pair at the position and advance, or report table end once the position
// reaches the end count) and mark end (end count takes the position).
// Configuration-type commands only raise an event code; no-action and unknown
// commands leave status_written low. Rate: one transaction per clock cycle
// sustained while results are taken; a stalled result side holds off new
// commands. An accepted command is captured in the read stage, which covers the
// read of the table memory, and moves to the result register whenever that is
// free. Position and end count update at acceptance, so back-to-back commands
// see each other's effects. No clearing pass is needed after reset: reads only
// reach entries written since reset.

module calibration_table_command_port #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [3:0]                          s_command,
    input  wire logic [15:0]                         s_value_a,
    input  wire logic [15:0]                         s_value_b,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_status_written,
    output logic      [2:0]                          m_status_code,
    output logic      [2:0]                          m_event_code,
    output logic      [15:0]                         m_point_distance,
    output logic      [15:0]                         m_point_volume,
    output logic      [$clog2(TABLE_DEPTH+1)-1:0]    m_end_value
);
    import ctpt_pkg::*;

    localparam int unsigned POS_W  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

    logic              cmd_fire;
    logic              advance;
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata;
    resp_t             ctrl_resp;
    logic [POS_W-1:0]  ctrl_end;

    // Read stage: waits on the memory read of a get point
    logic              pend_valid_reg;
    resp_t             pend_resp_reg;
    logic [POS_W-1:0]  pend_end_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_written_reg;
    status_t           out_status_reg;
    event_t            out_event_reg;
    logic [15:0]       out_dist_reg;
    logic [15:0]       out_vol_reg;
    logic [POS_W-1:0]  out_end_reg;

    // Move the read stage into the output register whenever that is free
    assign advance  = pend_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !pend_valid_reg || advance;
    assign cmd_fire = s_valid && s_ready;

    ctpt_cmd_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .POS_W       (POS_W),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_fire  (cmd_fire),
        .command   (s_command),
        .value_a   (s_value_a),
        .value_b   (s_value_b),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .resp      (ctrl_resp),
        .end_value (ctrl_end)
    );

    ctpt_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (32)
    ) u_table (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Control: hold the valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd_fire) begin
                pend_valid_reg <= 1'b1;
            end else if (advance) begin
                pend_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture the decoded result, then merge in the read data
    always_ff @(posedge aclk) begin
        if (cmd_fire) begin
            pend_resp_reg <= ctrl_resp;
            pend_end_reg  <= ctrl_end;
        end
        if (advance) begin
            out_written_reg <= pend_resp_reg.status_written;
            out_status_reg  <= pend_resp_reg.status_code;
            out_event_reg   <= pend_resp_reg.event_code;
            out_end_reg     <= pend_end_reg;
            if (pend_resp_reg.point_sent) begin
                out_dist_reg <= mem_rdata[31:16];
                out_vol_reg  <= mem_rdata[15:0];
            end else begin
                out_dist_reg <= '0;
                out_vol_reg  <= '0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status_written = out_written_reg;
    assign m_status_code    = out_status_reg;
    assign m_event_code     = out_event_reg;
    assign m_point_distance = out_dist_reg;
    assign m_point_volume   = out_vol_reg;
    assign m_end_value      = out_end_reg;

    a_unwritten_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status_written |-> m_status_code == ST_NULL && m_event_code == EV_NONE)
        else $error("status or event raised by a no-action command");

    a_point_only_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status_code != ST_SENT |-> m_point_distance == '0 && m_point_volume == '0)
        else $error("point data on a result that sent no point");

    a_pend_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && !advance |=> pend_valid_reg && $stable(pend_resp_reg)
            && (!pend_resp_reg.point_sent || $stable(mem_rdata)))
        else $error("stalled read stage lost its contents");

endmodule

`default_nettype wire
